// File: hw/rtl/fda_pkg.sv
package fda_pkg;

  localparam int unsigned FRAME_COLUMNS   = 720;
  localparam int unsigned FRAME_ROWS      = 480;
  localparam int unsigned COLOUR_CHANNELS = 3;
  localparam int unsigned FRAME_AREA      = FRAME_COLUMNS * FRAME_ROWS * COLOUR_CHANNELS;
  localparam int unsigned POS_W           = (FRAME_AREA > 1) ? $clog2(FRAME_AREA) : 1;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SUM_W    = 28;

  localparam logic [POS_W-1:0]    LAST_POS          = POS_W'(FRAME_AREA - 1);
  localparam logic [SUM_W-1:0]    SUM_MAX           = {SUM_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] DEFAULT_THRESHOLD = SAMPLE_W'(22);

  localparam int unsigned LINK_DEPTH = 4;
  localparam int unsigned LINK_PTR_W = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int unsigned LINK_CNT_W = $clog2(LINK_DEPTH + 1);

  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_PTR_W  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 2);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos;
    logic                last;
    logic                first;
  } fda_work_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] difference;
    logic                frame_done;
    logic [SUM_W-1:0]    activity_sum;
  } fda_result_t;

  typedef struct packed {
    logic                 stage_valid;
    logic [OUT_CNT_W-1:0] out_count;
  } fda_back_stat_t;

endpackage

// File: hw/rtl/fda_ram.sv
module fda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fda_front.sv
module fda_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [fda_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           link_full_i,
  output logic                           link_push_o,
  output fda_pkg::fda_work_t             link_item_o
);

  logic [fda_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      first_q, first_d;
  logic                      accept;
  logic                      last;

  assign accept = push_i && !link_full_i;
  assign last   = (pos_q == fda_pkg::LAST_POS);

  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    if (accept) begin
      pos_d = last ? '0 : pos_q + fda_pkg::POS_W'(1);
      if (last) begin
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

  assign link_push_o        = accept;
  assign link_item_o.sample = sample_i;
  assign link_item_o.pos    = pos_q;
  assign link_item_o.last   = last;
  assign link_item_o.first  = first_q;

endmodule

// File: hw/rtl/fda_link_queue.sv
module fda_link_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fda_pkg::fda_work_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output fda_pkg::fda_work_t item_o,
  output logic               empty_o
);

  fda_pkg::fda_work_t                 mem_q [fda_pkg::LINK_DEPTH];
  logic [fda_pkg::LINK_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [fda_pkg::LINK_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [fda_pkg::LINK_CNT_W-1:0]     count_q, count_d;

  localparam logic [fda_pkg::LINK_PTR_W-1:0] PtrLast =
    fda_pkg::LINK_PTR_W'(fda_pkg::LINK_DEPTH - 1);
  localparam logic [fda_pkg::LINK_CNT_W-1:0] CntFull =
    fda_pkg::LINK_CNT_W'(fda_pkg::LINK_DEPTH);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + fda_pkg::LINK_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + fda_pkg::LINK_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + fda_pkg::LINK_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - fda_pkg::LINK_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);

endmodule

// File: hw/rtl/fda_back.sv
module fda_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [fda_pkg::SAMPLE_W-1:0] threshold_i,
  input  logic                         link_empty_i,
  input  fda_pkg::fda_work_t           link_item_i,
  output logic                         link_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output fda_pkg::fda_result_t         result_o,
  output fda_pkg::fda_back_stat_t      stat_o
);

  localparam logic [fda_pkg::OUT_PTR_W-1:0] PtrLast =
    fda_pkg::OUT_PTR_W'(fda_pkg::OUT_DEPTH - 1);
  localparam logic [fda_pkg::OUT_CNT_W-1:0] CntFull =
    fda_pkg::OUT_CNT_W'(fda_pkg::OUT_DEPTH);

  // read stage
  logic                         issue;
  logic                         fwd;
  logic [fda_pkg::OUT_CNT_W-1:0] committed;

  // compute stage
  logic                         b_valid_q;
  fda_pkg::fda_work_t           b_item_q;
  logic                         b_fwd_q;
  logic [fda_pkg::SAMPLE_W-1:0] b_fwd_data_q;
  logic [fda_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [fda_pkg::SAMPLE_W-1:0] old_byte;
  logic [fda_pkg::SAMPLE_W-1:0] abs_diff;
  logic [fda_pkg::SAMPLE_W-1:0] kept;
  logic [fda_pkg::SUM_W:0]      sum_ext;
  logic [fda_pkg::SUM_W-1:0]    sum_sat;
  logic [fda_pkg::SUM_W-1:0]    run_q, run_d;
  fda_pkg::fda_result_t         res;

  // result queue
  fda_pkg::fda_result_t          out_mem_q [fda_pkg::OUT_DEPTH];
  logic [fda_pkg::OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [fda_pkg::OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [fda_pkg::OUT_CNT_W-1:0] count_q, count_d;
  logic                          out_pop;

  assign committed  = count_q + fda_pkg::OUT_CNT_W'(b_valid_q);
  assign issue      = !link_empty_i && (committed < CntFull);
  assign link_pop_o = issue;
  assign fwd        = b_valid_q && (link_item_i.pos == b_item_q.pos);

  fda_ram #(
    .WIDTH (fda_pkg::SAMPLE_W),
    .DEPTH (fda_pkg::FRAME_AREA)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_item_q.pos),
    .wdata_i (b_item_q.sample),
    .re_i    (issue),
    .raddr_i (link_item_i.pos),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      run_q     <= '0;
    end else begin
      b_valid_q <= issue;
      run_q     <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_item_q     <= link_item_i;
      b_fwd_q      <= fwd;
      b_fwd_data_q <= b_item_q.sample;
    end
  end

  // first frame after reset compares against zeros
  always_comb begin
    if (b_item_q.first) begin
      old_byte = '0;
    end else if (b_fwd_q) begin
      old_byte = b_fwd_data_q;
    end else begin
      old_byte = ram_rdata;
    end
    abs_diff = (b_item_q.sample >= old_byte) ? (b_item_q.sample - old_byte)
                                             : (old_byte - b_item_q.sample);
    kept     = (abs_diff < threshold_i) ? '0 : abs_diff;
    sum_ext  = {1'b0, run_q} + (fda_pkg::SUM_W + 1)'(kept);
    sum_sat  = sum_ext[fda_pkg::SUM_W] ? fda_pkg::SUM_MAX : sum_ext[fda_pkg::SUM_W-1:0];
    run_d    = run_q;
    if (b_valid_q) begin
      run_d = b_item_q.last ? '0 : sum_sat;
    end
    res.difference   = kept;
    res.frame_done   = b_item_q.last;
    res.activity_sum = b_item_q.last ? sum_sat : '0;
  end

  assign out_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (b_valid_q) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + fda_pkg::OUT_PTR_W'(1);
    end
    if (out_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + fda_pkg::OUT_PTR_W'(1);
    end
    if (b_valid_q && !out_pop) begin
      count_d = count_q + fda_pkg::OUT_CNT_W'(1);
    end else if (out_pop && !b_valid_q) begin
      count_d = count_q - fda_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      out_mem_q[wr_ptr_q] <= res;
    end
  end

  assign result_o           = out_mem_q[rd_ptr_q];
  assign empty_o            = (count_q == '0);
  assign stat_o.stage_valid = b_valid_q;
  assign stat_o.out_count   = count_q;

endmodule

// File: hw/rtl/frame_difference_activity_top.sv
// Frame differencing activity detector.
// Input queue: drive sample_i with push; the item is taken at a clock edge
// where push is high and full is low. One byte per item, raster order,
// all colour channels of a frame in sequence.
// Result queue: while empty is low the oldest item sits on difference_o,
// frame_done_o and activity_sum_o; pop takes it. frame_done_o marks the
// last byte of a frame, where activity_sum_o holds the frame's kept sum.
// Threshold: noise_threshold_i is written when noise_threshold_we_i is high;
// the user must write it only while no item is in flight, which the block
// itself does not enforce; it resets to 22.
// Throughput: one item per cycle while the result queue has room, set by the
// one read and one write port of the frame memory used once per item each.
// A 4-entry queue sits between the classify front and the memory back, and a
// 4-entry result queue at the output; when the receiver stalls, these fill
// and full rises, no item is dropped.
// Reset: position, sums and queues clear at once; the frame memory is not
// swept, the first frame after reset is compared against zeros instead.
module frame_difference_activity_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         noise_threshold_we_i,
  input  logic [fda_pkg::SAMPLE_W-1:0] noise_threshold_i,
  input  logic                         push,
  output logic                         full,
  input  logic [fda_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [fda_pkg::SAMPLE_W-1:0] difference_o,
  output logic                         frame_done_o,
  output logic [fda_pkg::SUM_W-1:0]    activity_sum_o
);

  logic [fda_pkg::SAMPLE_W-1:0] noise_threshold_q;
  logic                         link_push;
  fda_pkg::fda_work_t           link_in;
  logic                         link_full;
  logic                         link_pop;
  fda_pkg::fda_work_t           link_out;
  logic                         link_empty;
  fda_pkg::fda_result_t         result;
  fda_pkg::fda_back_stat_t      back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_threshold_q <= fda_pkg::DEFAULT_THRESHOLD;
    end else if (noise_threshold_we_i) begin
      noise_threshold_q <= noise_threshold_i;
    end
  end

  fda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .sample_i    (sample_i),
    .link_full_i (link_full),
    .link_push_o (link_push),
    .link_item_o (link_in)
  );

  fda_link_queue u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (link_push),
    .item_i  (link_in),
    .full_o  (link_full),
    .pop_i   (link_pop),
    .item_o  (link_out),
    .empty_o (link_empty)
  );

  fda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (noise_threshold_q),
    .link_empty_i (link_empty),
    .link_item_i  (link_out),
    .link_pop_o   (link_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result),
    .stat_o       (back_stat)
  );

  assign full           = link_full;
  assign difference_o   = result.difference;
  assign frame_done_o   = result.frame_done;
  assign activity_sum_o = result.activity_sum;

  a_diff_above_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && difference_o != '0) |-> (difference_o >= noise_threshold_q))
    else $error("kept difference below threshold");

  a_sum_only_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !frame_done_o) |-> (activity_sum_o == '0))
    else $error("activity sum outside frame end");

  a_result_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((int'(back_stat.out_count) + int'(back_stat.stage_valid)) <= fda_pkg::OUT_DEPTH))
    else $error("result queue overcommitted");

endmodule
